FILE: hdl/q4bd_pkg.sv
// Shared types and constants for the 4-bit by 8-bit block dot accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package q4bd_pkg;

    // Block geometry: 16 weight bytes, each feeding two activations
    localparam int unsigned LANES    = 16;
    localparam int unsigned GROUPS   = 4;
    localparam int unsigned GRP_SIZE = LANES / GROUPS;

    // Datapath widths
    localparam int unsigned LANE_W  = 13;  // two nibble x byte products
    localparam int unsigned GRP_W   = 15;  // sum of four lanes
    localparam int unsigned DOT_W   = 17;  // sum of all 16 lanes
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned PROD1_W = DOT_W + SCALE_W;    // dot * weight_scale
    localparam int unsigned TERM_W  = PROD1_W + SCALE_W;  // * act_scale
    localparam int unsigned ACC_W   = 64;

    // Stream packing
    localparam int unsigned S_DATA_W = 416;
    localparam int unsigned M_DATA_W = 64;
    localparam int unsigned ACT_BASE = 128;  // activations start after weight bytes
    localparam int unsigned WS_LSB   = 384;
    localparam int unsigned AS_LSB   = 400;

    // Nibble offset that centers a 4-bit weight on zero
    localparam logic signed [4:0] NIBBLE_BIAS = 5'sd8;

    // Sideband that travels with a block down the pipeline
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic signed [SCALE_W-1:0] weight_scale;
        logic signed [SCALE_W-1:0] act_scale;
    } side_t;

endpackage

`default_nettype wire

FILE: hdl/q4_block_dot_fixed_scale_accum_top.sv
// Top level of the 4-bit weight by 8-bit activation block dot accumulator.
// Depends on q4bd_pkg, q4bd_lane, q4bd_merge and q4bd_scale_accum.
//
// Each request carries one 32-element block; 16 lanes form the per-byte
// products, a two-level adder tree merges them, two multiplier stages apply
// the weight and activation scales, and a 64-bit wrapping accumulator sums
// the row. A block with tlast set emits the row sum and clears the
// accumulator. Throughput is one block per cycle unless a result is stalled.
// The lane register loads on the edge that accepts a last block, then the two
// tree, two multiplier and accumulate registers follow; m_tvalid rises with
// the accumulate register. A stalled result holds the whole pipeline, so
// s_tready is low only while m_tvalid waits on m_tready.
`default_nettype none

module q4_block_dot_fixed_scale_accum_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // Block requests
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // weight_bytes_low[63:0], weight_bytes_high[127:64], act_bytes_0_7[191:128],
    // act_bytes_8_15[255:192], act_bytes_16_23[319:256], act_bytes_24_31[383:320],
    // weight_scale[399:384], act_scale[415:400]
    input  wire logic [415:0]  s_tdata,
    input  wire logic          s_tlast,   // last_block
    // Row results
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata    // row_sum[63:0]
);
    import q4bd_pkg::*;

    logic                      en;
    logic signed [LANE_W-1:0]  lane_sum [LANES];
    side_t                     side_in;
    side_t                     side0_reg;
    side_t                     side2;
    logic signed [DOT_W-1:0]   dot;

    // Whole pipeline advances unless a result is stuck
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Sideband for the accepted request
    assign side_in.valid        = s_tvalid;
    assign side_in.last         = s_tlast;
    assign side_in.weight_scale = $signed(s_tdata[WS_LSB +: SCALE_W]);
    assign side_in.act_scale    = $signed(s_tdata[AS_LSB +: SCALE_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side0_reg <= '0;
        end else if (en) begin
            side0_reg <= side_in;
        end
    end

    // Lanes: weight byte j pairs with activations j and j+16
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        q4bd_lane u_lane (
            .aclk         (aclk),
            .en           (en),
            .weight_byte  (s_tdata[8*j +: 8]),
            .act_lo       ($signed(s_tdata[ACT_BASE + 8*j +: 8])),
            .act_hi       ($signed(s_tdata[ACT_BASE + 8*(j + LANES) +: 8])),
            .lane_sum_reg (lane_sum[j])
        );
    end

    q4bd_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .lane_sum (lane_sum),
        .side_in  (side0_reg),
        .dot_reg  (dot),
        .side_out (side2)
    );

    q4bd_scale_accum u_scale_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .dot           (dot),
        .side_in       (side2),
        .out_taken     (m_tready),
        .out_valid_reg (m_tvalid),
        .out_sum_reg   (m_tdata)
    );

endmodule

`default_nettype wire

FILE: hdl/q4bd_lane.sv
// One lane: weight byte j against activations j and j+16, summed and registered.
// Depends on q4bd_pkg.
`default_nettype none

module q4bd_lane (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic [7:0]                          weight_byte,
    input  wire logic signed [7:0]                   act_lo,
    input  wire logic signed [7:0]                   act_hi,
    output logic signed [q4bd_pkg::LANE_W-1:0]       lane_sum_reg
);
    import q4bd_pkg::*;

    logic signed [4:0]        w_lo;
    logic signed [4:0]        w_hi;
    logic signed [LANE_W-1:0] prod_lo;
    logic signed [LANE_W-1:0] prod_hi;
    logic signed [LANE_W-1:0] lane_sum_next;

    // Unpack nibbles into signed weights, -8..7
    assign w_lo = $signed({1'b0, weight_byte[3:0]}) - NIBBLE_BIAS;
    assign w_hi = $signed({1'b0, weight_byte[7:4]}) - NIBBLE_BIAS;

    // Two small products, each within -1016..1024
    assign prod_lo       = LANE_W'(w_lo) * LANE_W'(act_lo);
    assign prod_hi       = LANE_W'(w_hi) * LANE_W'(act_hi);
    assign lane_sum_next = prod_lo + prod_hi;

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_sum_reg <= lane_sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/q4bd_merge.sv
// Two-level registered adder tree that merges the 16 lane sums into the dot.
// Depends on q4bd_pkg.
`default_nettype none

module q4bd_merge (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic signed [q4bd_pkg::LANE_W-1:0]  lane_sum [q4bd_pkg::LANES],
    input  wire q4bd_pkg::side_t                     side_in,
    output logic signed [q4bd_pkg::DOT_W-1:0]        dot_reg,
    output q4bd_pkg::side_t                          side_out
);
    import q4bd_pkg::*;

    logic signed [GRP_W-1:0] grp_reg  [GROUPS];
    logic signed [GRP_W-1:0] grp_next [GROUPS];
    logic signed [DOT_W-1:0] dot_next;
    side_t                   side1_reg;
    side_t                   side2_reg;

    // First level: four lanes per group
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                grp_next[g] = grp_next[g] + GRP_W'(lane_sum[g*GRP_SIZE + k]);
            end
        end
    end

    // Second level: the four group sums
    always_comb begin
        dot_next = '0;
        for (int g = 0; g < GROUPS; g++) begin
            dot_next = dot_next + DOT_W'(grp_reg[g]);
        end
    end

    // Data registers
    always_ff @(posedge aclk) begin
        if (en) begin
            grp_reg <= grp_next;
            dot_reg <= dot_next;
        end
    end

    // Sideband follows the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg <= '0;
            side2_reg <= '0;
        end else if (en) begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
        end
    end

    assign side_out = side2_reg;

endmodule

`default_nettype wire

FILE: hdl/q4bd_scale_accum.sv
// Scales the dot by both block scales, accumulates into the row sum and holds
// the result register. Depends on q4bd_pkg.
`default_nettype none

module q4bd_scale_accum (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic signed [q4bd_pkg::DOT_W-1:0]   dot,
    input  wire q4bd_pkg::side_t                     side_in,
    input  wire logic                                out_taken,
    output logic                                     out_valid_reg,
    output logic [q4bd_pkg::ACC_W-1:0]               out_sum_reg
);
    import q4bd_pkg::*;

    logic signed [PROD1_W-1:0] prod1_reg;
    logic signed [TERM_W-1:0]  term_reg;
    side_t                     side3_reg;
    side_t                     side4_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          sum_next;

    // Multiplier stages, one product per register
    always_ff @(posedge aclk) begin
        if (en) begin
            prod1_reg <= PROD1_W'(dot) * PROD1_W'(side_in.weight_scale);
            term_reg  <= TERM_W'(prod1_reg) * TERM_W'(side3_reg.act_scale);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side3_reg <= '0;
            side4_reg <= '0;
        end else if (en) begin
            side3_reg <= side_in;
            side4_reg <= side3_reg;
        end
    end

    // Wrapping row sum including the current block
    assign sum_next = acc_reg + ACC_W'(term_reg);

    // Accumulator and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_taken) begin
                out_valid_reg <= 1'b0;
            end
            if (en && side4_reg.valid) begin
                if (side4_reg.last) begin
                    acc_reg       <= '0;
                    out_valid_reg <= 1'b1;
                end else begin
                    acc_reg <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && side4_reg.valid && side4_reg.last) begin
            out_sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/q4bd_checker.sv
// Port-level checker for the block dot accumulator, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module q4bd_checker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    input  wire logic          s_tlast,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [63:0]   m_tdata
);

    logic [3:0] open_rows_reg;
    logic [3:0] open_rows_next;

    // Rows whose last block went in and whose sum has not been taken yet
    assign open_rows_next = open_rows_reg + 4'(s_tvalid && s_tready && s_tlast)
                            - 4'(m_tvalid && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_rows_reg <= '0;
        end else begin
            open_rows_reg <= open_rows_next;
        end
    end

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input is held back only by a stalled result
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow result backpressure");

    // A stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // A result is shown only for a row whose last block was accepted
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_rows_reg != 4'd0)
        else $error("result without a matching request");

endmodule

bind q4_block_dot_fixed_scale_accum_top q4bd_checker u_q4bd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for q4_block_dot_fixed_scale_accum_top: streams 4-bit/8-bit blocks
// with random valid/ready gaps and checks each row sum against an in-bench predictor.
// Depends on q4bd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
    import q4bd_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 1750;
    localparam int QUIET_ITEMS  = 250;   // final stretch driven with no idling
    localparam int HOLD_CYCLES  = 300;   // long receiver stall
    localparam int TAIL_CYCLES  = 20;    // settle time after the last row sum
    localparam int CYCLE_LIMIT  = 400000;

    // Request payload, first member in the top bits so it maps straight onto s_tdata
    typedef struct packed {
        logic signed [SCALE_W-1:0] act_scale;
        logic signed [SCALE_W-1:0] weight_scale;
        logic [63:0]               act_24_31;
        logic [63:0]               act_16_23;
        logic [63:0]               act_8_15;
        logic [63:0]               act_0_7;
        logic [63:0]               weight_high;
        logic [63:0]               weight_low;
    } block_t;

    // Row sum scoreboard: predicts each block's scaled dot and queues row sums
    class row_sum_board;
        logic [ACC_W-1:0] row_acc;
        logic [ACC_W-1:0] pending[$];
        int               errors;
        int               rows_checked;
        int               blocks_seen;

        function new();
            row_acc      = '0;
            errors       = 0;
            rows_checked = 0;
            blocks_seen  = 0;
        endfunction

        // Scaled dot product of one 32-element block
        function longint scaled_dot(block_t b);
            logic [127:0] wbytes;
            logic [255:0] acts;
            logic [7:0]   wb;
            int           dot;
            int           w_lo;
            int           w_hi;
            wbytes = {b.weight_high, b.weight_low};
            acts   = {b.act_24_31, b.act_16_23, b.act_8_15, b.act_0_7};
            dot    = 0;
            for (int j = 0; j < 16; j++) begin
                wb   = wbytes[8*j +: 8];
                w_lo = int'(wb[3:0]) - 8;
                w_hi = int'(wb[7:4]) - 8;
                dot += w_lo * int'($signed(acts[8*j +: 8]));
                dot += w_hi * int'($signed(acts[8*(j+16) +: 8]));
            end
            return longint'(dot) * longint'(b.weight_scale) * longint'(b.act_scale);
        endfunction

        function void note_block(block_t b, logic last);
            blocks_seen++;
            row_acc = row_acc + scaled_dot(b);
            if (last) begin
                pending.push_back(row_acc);
                row_acc = '0;
            end
        endfunction

        function void check_sum(logic [ACC_W-1:0] got);
            logic [ACC_W-1:0] want;
            if (pending.size() == 0) begin
                $error("row_sum: no result expected, actual %0d", $signed(got));
                errors++;
                return;
            end
            want = pending.pop_front();
            rows_checked++;
            if (got !== want) begin
                $error("row_sum mismatch: expected %0d, actual %0d",
                       $signed(want), $signed(got));
                errors++;
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [415:0]     s_tdata;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [63:0]      m_tdata;

    row_sum_board board = new();
    int  cycle_count;
    int  items_sent;
    int  rows_sent;
    bit  quiet;
    bit  send_idle_on;
    bit  recv_idle_on;
    bit  hold_request;

    q4_block_dot_fixed_scale_accum_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // Watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Handshake monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_block(block_t'(s_tdata), s_tlast);
            if (m_tvalid && m_tready)
                board.check_sum(m_tdata);
        end
    end

    // Result receiver: random stall bursts, plus one long hold on request
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else if (!quiet && recv_idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Sixteen copies of each byte: weights, low-half and high-half activations
    function automatic block_t fill_block(logic [7:0] wb, logic [7:0] a_lo, logic [7:0] a_hi,
                                          logic signed [15:0] ws, logic signed [15:0] as_v);
        block_t b;
        b.weight_low   = {8{wb}};
        b.weight_high  = {8{wb}};
        b.act_0_7      = {8{a_lo}};
        b.act_8_15     = {8{a_lo}};
        b.act_16_23    = {8{a_hi}};
        b.act_24_31    = {8{a_hi}};
        b.weight_scale = ws;
        b.act_scale    = as_v;
        return b;
    endfunction

    function automatic logic signed [15:0] pick_scale();
        case ($urandom_range(0, 11))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random block, biased now and then toward the extremes of each field
    function automatic block_t rand_block();
        block_t       b;
        logic [415:0] raw;
        for (int k = 0; k < 13; k++)
            raw[32*k +: 32] = $urandom;
        b = block_t'(raw);
        case ($urandom_range(0, 11))
            0: begin b.weight_low = '0; b.weight_high = '0; end
            1: begin b.weight_low = '1; b.weight_high = '1; end
            2: begin
                b.act_0_7 = {8{8'h80}}; b.act_8_15 = {8{8'h80}};
                b.act_16_23 = {8{8'h80}}; b.act_24_31 = {8{8'h80}};
            end
            3: begin
                b.act_0_7 = {8{8'h7F}}; b.act_8_15 = {8{8'h7F}};
                b.act_16_23 = {8{8'h7F}}; b.act_24_31 = {8{8'h7F}};
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) b.weight_scale = pick_scale();
        if ($urandom_range(0, 3) == 0) b.act_scale    = pick_scale();
        return b;
    endfunction

    // Offer one request; entered and left on a falling edge
    task automatic send_block(input block_t b, input logic last);
        if (!quiet && send_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (last) rows_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random_row(input int len);
        for (int k = 0; k < len; k++)
            send_block(rand_block(), k == len - 1);
    endtask

    // Stop offering and wait for every queued row sum
    task automatic drain_rows();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        bit hold_done;
        bit pause_done;
        int len;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        items_sent   = 0;
        rows_sent    = 0;
        quiet        = 1'b0;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: field extremes, nibble halves, zero scales, multi-block rows
        send_block(fill_block(8'h00, 8'h00, 8'h00, 16'sh0000, 16'sh0000), 1'b1);
        send_block(fill_block(8'h00, 8'h80, 8'h80, 16'sh8000, 16'sh8000), 1'b1);
        send_block(fill_block(8'h00, 8'h80, 8'h80, 16'sh7FFF, 16'sh8000), 1'b1);
        send_block(fill_block(8'hFF, 8'h7F, 8'h7F, 16'sh7FFF, 16'sh7FFF), 1'b0);
        send_block(fill_block(8'h00, 8'h7F, 8'h7F, 16'sh8000, 16'sh7FFF), 1'b1);
        // low nibble only against the low half, high nibble against the high half
        send_block(fill_block(8'h0F, 8'h7F, 8'h80, 16'shFFFF, 16'sh0001), 1'b1);
        send_block(fill_block(8'hF0, 8'h80, 8'h7F, 16'sh0001, 16'shFFFF), 1'b1);
        send_block(fill_block(8'hF0, 8'h01, 8'h00, 16'sh7FFF, 16'sh0001), 1'b1);
        // weights of zero after the bias
        send_block(fill_block(8'h88, 8'h80, 8'h7F, 16'sh7FFF, 16'sh7FFF), 1'b1);
        // zero scales on a nonzero dot
        send_block(fill_block(8'hFF, 8'h80, 8'h80, 16'sh0000, 16'sh7FFF), 1'b1);
        send_block(fill_block(8'hFF, 8'h80, 8'h80, 16'sh8000, 16'sh0000), 1'b1);
        // four largest terms into one row
        for (int k = 0; k < 4; k++)
            send_block(fill_block(8'h00, 8'h80, 8'h80, 16'sh8000, 16'sh8000), k == 3);
        for (int k = 0; k < 4; k++)
            send_block(fill_block(8'h00, 8'h80, 8'h80, 16'sh7FFF, 16'sh8000), k == 3);
        for (int k = 0; k < 3; k++)
            send_block(rand_block(), 1'b1);

        // Random rows: mostly short, some long; idling switched per segment
        while (items_sent < ITEM_TARGET - QUIET_ITEMS) begin
            send_idle_on = $urandom_range(0, 3) != 0;
            recv_idle_on = $urandom_range(0, 3) != 0;
            for (int r = 0; r < 8; r++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 4);
                send_random_row(len);
            end
            if (!hold_done && items_sent > 500) begin
                // receiver stalls while single-block rows keep coming
                hold_done    = 1'b1;
                hold_request = 1'b1;
                for (int r = 0; r < 40; r++)
                    send_block(rand_block(), 1'b1);
            end
            if (!pause_done && items_sent > 1000) begin
                pause_done = 1'b1;
                drain_rows();
            end
        end

        // Final stretch at full rate on both sides
        quiet = 1'b1;
        while (items_sent < ITEM_TARGET)
            send_random_row($urandom_range(1, 4));

        drain_rows();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Sent %0d blocks in %0d rows, including full-scale terms and long stalls;",
                 items_sent, rows_sent);
        $display("compared %0d row sums, %0d mismatches.", board.rows_checked, board.errors);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/q4bd_pkg.sv
hdl/q4bd_lane.sv
hdl/q4bd_merge.sv
hdl/q4bd_scale_accum.sv
hdl/q4_block_dot_fixed_scale_accum_top.sv
hdl/q4bd_checker.sv
bench/testbench.sv
